@@ sv/stit_pkg.sv @@
// Package with the shared types and constants of the sorted table insert block.
`timescale 1ns / 1ps

package stit_pkg;

    localparam int VALUE_W             = 32;
    localparam int OPCODE_W            = 3;
    localparam int COUNT_W             = 5;
    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int POSITION_STRIDE     = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_CLEAR     = 3'd1,
        OP_READ_ALL  = 3'd2,
        OP_READ_ODD  = 3'd3,
        OP_READ_EVEN = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_RD_EMIT,
        ST_RESP
    } state_t;

    // One result beat as it travels from the sequencer to the output register.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               empty;
        logic               drop;
        logic [COUNT_W-1:0] count;
    } res_t;

endpackage

@@ sv/stit_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module stit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/stit_seq.sv @@
// Sequencer that runs inserts, clears and readouts against the table memory.
`timescale 1ns / 1ps

module stit_seq #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [stit_pkg::OPCODE_W-1:0]       in_opcode,
    input  logic [stit_pkg::VALUE_W-1:0]        in_value,
    output logic                                res_valid,
    input  logic                                res_ready,
    output stit_pkg::res_t                      res,
    output logic                                ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]      ram_waddr,
    output logic [stit_pkg::VALUE_W-1:0]        ram_wdata,
    output logic                                ram_re,
    output logic [$clog2(TABLE_DEPTH)-1:0]      ram_raddr,
    input  logic [stit_pkg::VALUE_W-1:0]        ram_rdata
);

    import stit_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int PW     = CNT_W + 1;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic               stride_reg, stride_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic               empty_reg, empty_next;
    logic               drop_reg, drop_next;

    opcode_t       op;
    logic          accept;
    logic          is_full;
    logic [PW-1:0] count_ext;
    logic [PW-1:0] start_pos;
    logic          rd_none;
    logic          greater;
    logic [PW-1:0] step;
    logic [PW-1:0] pos_step;
    logic [PW-1:0] pos_dec;
    logic          rd_last;

    assign op        = opcode_t'(in_opcode);
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign is_full   = (count_reg == CNT_W'(TABLE_DEPTH));
    assign count_ext = PW'(count_reg);
    assign start_pos = (op == OP_READ_EVEN) ? PW'(1) : PW'(0);
    assign rd_none   = (start_pos >= count_ext);
    assign greater   = ($signed(ram_rdata) > $signed(value_reg));
    assign step      = stride_reg ? PW'(POSITION_STRIDE) : PW'(1);
    assign pos_step  = pos_reg + step;
    assign pos_dec   = pos_reg - PW'(1);
    assign rd_last   = (pos_step >= count_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        stride_reg <= stride_next;
        value_reg  <= value_next;
        empty_reg  <= empty_next;
        drop_reg   <= drop_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_INSERT:
                        begin
                            if (is_full)
                                state_next = ST_RESP;
                            else if (count_reg == '0)
                                state_next = ST_INS_PUT;
                            else
                                state_next = ST_INS_CMP;
                        end
                        OP_CLEAR:
                            state_next = ST_RESP;
                        OP_READ_ALL, OP_READ_ODD, OP_READ_EVEN:
                            state_next = rd_none ? ST_RESP : ST_RD_EMIT;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_INS_CMP:
            begin
                if (!greater)
                    state_next = ST_RESP;
                else if (pos_reg == PW'(1))
                    state_next = ST_INS_PUT;
            end
            ST_INS_PUT:
                state_next = ST_RESP;
            ST_RD_EMIT:
            begin
                if (res_ready && rd_last)
                    state_next = ST_IDLE;
            end
            ST_RESP:
            begin
                if (res_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Memory controls, result beat and datapath registers.
    always_comb
    begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        stride_next = stride_reg;
        value_next  = value_reg;
        empty_next  = empty_reg;
        drop_next   = drop_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg[ADDR_W-1:0];
        ram_wdata   = value_reg;
        ram_re      = 1'b0;
        ram_raddr   = pos_dec[ADDR_W-1:0];
        res_valid   = 1'b0;
        res.value   = '0;
        res.last    = 1'b1;
        res.empty   = empty_reg;
        res.drop    = drop_reg;
        res.count   = COUNT_W'(count_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    empty_next = 1'b0;
                    drop_next  = 1'b0;
                    case (op)
                        OP_INSERT:
                        begin
                            value_next = in_value;
                            pos_next   = count_ext;
                            if (is_full)
                            begin
                                drop_next = 1'b1;
                            end
                            else if (count_reg != '0)
                            begin
                                // Fetch the current top entry for the first compare.
                                ram_re    = 1'b1;
                                ram_raddr = ADDR_W'(count_reg - CNT_W'(1));
                            end
                        end
                        OP_CLEAR:
                            count_next = '0;
                        OP_READ_ALL, OP_READ_ODD, OP_READ_EVEN:
                        begin
                            stride_next = (op != OP_READ_ALL);
                            pos_next    = start_pos;
                            if (rd_none)
                            begin
                                empty_next = 1'b1;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = start_pos[ADDR_W-1:0];
                            end
                        end
                        default:
                        begin
                            empty_next = empty_reg;
                            drop_next  = drop_reg;
                        end
                    endcase
                end
            end
            ST_INS_CMP:
            begin
                ram_we = 1'b1;
                if (greater)
                begin
                    // Move the larger entry up one place and fetch the one below it.
                    ram_wdata = ram_rdata;
                    pos_next  = pos_dec;
                    if (pos_reg != PW'(1))
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(pos_dec - PW'(1));
                    end
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ST_INS_PUT:
            begin
                ram_we     = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
            ST_RD_EMIT:
            begin
                res_valid = 1'b1;
                res.value = ram_rdata;
                res.last  = rd_last;
                res.empty = 1'b0;
                res.drop  = 1'b0;
                if (res_ready && !rd_last)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = pos_step[ADDR_W-1:0];
                    pos_next  = pos_step;
                end
            end
            ST_RESP:
                res_valid = 1'b1;
            default:
            begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    a_write_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_INS_CMP || state_reg == ST_INS_PUT))
        else $error("table written outside an insert");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_EMIT) |-> (pos_reg < count_ext))
        else $error("readout position beyond held entries");

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write to the same entry in one cycle");

    a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !res_valid)
        else $error("result offered while taking a new operation");
`endif

endmodule

@@ sv/stit_out_reg.sv @@
// Output register stage that holds one result beat for the master side.
`timescale 1ns / 1ps

module stit_out_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_valid,
    output logic           res_ready,
    input  stit_pkg::res_t res,
    output logic           m_valid,
    input  logic           m_ready,
    output stit_pkg::res_t m_res
);

    import stit_pkg::*;

    logic valid_reg, valid_next;
    res_t data_reg, data_next;

    assign res_ready = !valid_reg || m_ready;
    assign m_valid   = valid_reg;
    assign m_res     = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_ready)
        begin
            valid_next = res_valid;
            if (res_valid)
                data_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ sv/sorted_table_insert_split.sv @@
// Top level of the sorted table: sequencer, table memory and output register.
`timescale 1ns / 1ps

// Keeps up to TABLE_DEPTH signed 32-bit values in ascending order in one
// synchronous memory. Each operation arrives as one beat on the slave side;
// its opcode sits in s_axis_tuser and the value in s_axis_tdata. An insert
// compares against held entries from the top down, moving each larger entry
// up one place, one entry per cycle, then writes the new value into the gap.
// The walk steps past the k entries larger than the new value (at most
// TABLE_DEPTH - 1), since each step needs the memory's read port and its
// registered read data. A dropped insert on a full table, a clear and an
// empty read each give a single result beat. An ignored opcode gives no
// result. A readout gives one beat per cycle while the master side is
// ready, once the registered read of its first entry is back. One operation
// is worked on at a time; the next beat is taken as soon as the last result
// of the current one has entered the output register, even if that beat is
// still waiting on the master side. Entries are only read below the held
// count, so the memory needs no clearing after reset. The result beat
// carries the count of held entries after the operation, and tlast marks
// the final beat of each operation.

module sorted_table_insert_split #(
    parameter int TABLE_DEPTH = stit_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [7:0]  s_axis_tuser,   // [2:0] opcode, [7:3] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] out_value, [36:32] count, [39:37] zero
    output logic        m_axis_tlast,
    output logic [7:0]  m_axis_tuser    // [0] empty_res, [1] full_drop, [7:2] zero
);

    import stit_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic               res_valid;
    logic               res_ready;
    res_t               res;
    res_t               m_res;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    // Control: walks each operation through the table memory.
    stit_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_opcode (s_axis_tuser[OPCODE_W-1:0]),
        .in_value  (s_axis_tdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // The sorted entries themselves.
    stit_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register parts the sequencer from the master side.
    stit_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_res     (m_res)
    );

    assign m_axis_tdata = {3'b000, m_res.count, m_res.value};
    assign m_axis_tlast = m_res.last;
    assign m_axis_tuser = {6'b000000, m_res.drop, m_res.empty};

endmodule

@@ sim/sorted_table_insert_split_tb.sv @@
// Self-checking testbench for the sorted table insert block, with a built-in table predictor.
`timescale 1ns / 1ps

module sorted_table_insert_split_tb;
    import stit_pkg::*;

    localparam int TABLE_DEPTH  = DEFAULT_TABLE_DEPTH;
    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 11;
    // A full readout plus an insert that shifts every entry, with margin.
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
    localparam int HOLD_CYCLES  = 300;
    // The longest quiet stretch of a correct run is the receiver hold-off;
    // random stalls and the longest insert are far shorter.
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 40;

    // Opcodes the block must ignore without giving any result.
    localparam logic [OPCODE_W-1:0] OP_UNUSED_5 = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_7 = 3'd7;

    logic               clk;
    logic               rst_n         = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [31:0]        s_axis_tdata  = '0;
    logic [7:0]         s_axis_tuser  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [39:0]        m_axis_tdata;
    logic               m_axis_tlast;
    logic [7:0]         m_axis_tuser;

    int                 send_idle_pct = 0;
    int                 rx_stall_pct  = 0;
    bit                 hold_request  = 1'b0;
    int                 items_sent    = 0;
    int                 fail_count    = 0;

    // Predicted contents of the table and the beats still owed by the block.
    logic signed [VALUE_W-1:0] sorted_vals [TABLE_DEPTH];
    int                        held_count = 0;
    res_t                      expected_beats [$];

    sorted_table_insert_split #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic void push_expected(input logic [VALUE_W-1:0] value, input logic last,
                                          input logic empty, input logic drop);
        res_t beat;
        beat.value = value;
        beat.last  = last;
        beat.empty = empty;
        beat.drop  = drop;
        beat.count = COUNT_W'(held_count);
        expected_beats.push_back(beat);
    endfunction

    // Applies one operation to the predicted table and queues the beats it gives.
    function automatic void predict_op(input logic [OPCODE_W-1:0] op,
                                       input logic signed [VALUE_W-1:0] value);
        int pos;
        int first;
        int stride;
        int n_out;
        case (op)
            OP_INSERT:
            begin
                if (held_count >= TABLE_DEPTH)
                begin
                    push_expected('0, 1'b1, 1'b0, 1'b1);
                end
                else
                begin
                    pos = held_count;
                    while (pos > 0 && sorted_vals[pos-1] > value)
                    begin
                        sorted_vals[pos] = sorted_vals[pos-1];
                        pos--;
                    end
                    sorted_vals[pos] = value;
                    held_count++;
                    push_expected('0, 1'b1, 1'b0, 1'b0);
                end
            end
            OP_CLEAR:
            begin
                held_count = 0;
                push_expected('0, 1'b1, 1'b0, 1'b0);
            end
            OP_READ_ALL, OP_READ_ODD, OP_READ_EVEN:
            begin
                first  = (op == OP_READ_EVEN) ? 1 : 0;
                stride = (op == OP_READ_ALL) ? 1 : POSITION_STRIDE;
                n_out  = 0;
                for (pos = first; pos < held_count; pos += stride)
                begin
                    push_expected(sorted_vals[pos], (pos + stride >= held_count), 1'b0, 1'b0);
                    n_out++;
                end
                // Nothing at the asked positions: a single empty-marked beat.
                if (n_out == 0)
                    push_expected('0, 1'b1, 1'b1, 1'b0);
            end
            default: ;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            // Small values around zero give many equal entries.
            4, 5:    return 32'($urandom_range(0, 20)) - 32'd10;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_read();
        case ($urandom_range(0, 2))
            0:       return OP_READ_ALL;
            1:       return OP_READ_ODD;
            default: return OP_READ_EVEN;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [39:0] want,
                                 input logic [39:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    endtask

    // Offers one beat, idling first at random, and waits until it is taken.
    // The valid stays high on return so that a following beat can go back to back.
    task automatic send_beat(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= {{(8 - OPCODE_W){1'b0}}, op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_op(op, value);
        if (op <= OP_READ_EVEN)
            items_sent++;
    endtask

    // Receiver: random stalls, and one long hold-off when the test asks for it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Every result beat is checked against the oldest outstanding prediction.
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_beats.size() == 0)
            begin
                note_mismatch("beat with none outstanding, tdata", '0, m_axis_tdata);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (m_axis_tdata[31:0] !== want.value)
                    note_mismatch("out_value", want.value, m_axis_tdata[31:0]);
                if (m_axis_tdata[36:32] !== want.count)
                    note_mismatch("count", want.count, m_axis_tdata[36:32]);
                if (m_axis_tlast !== want.last)
                    note_mismatch("last", want.last, m_axis_tlast);
                if (m_axis_tuser[0] !== want.empty)
                    note_mismatch("empty_res", want.empty, m_axis_tuser[0]);
                if (m_axis_tuser[1] !== want.drop)
                    note_mismatch("full_drop", want.drop, m_axis_tuser[1]);
            end
        end
    end

    // Watchdog: ends the run when neither side has moved a beat for too long.
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (rst_n && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Empty reads, a one-entry table, extremes and duplicates up to a full table,
    // an insert into a full table, every readout of it, an ignored opcode and a clear.
    task automatic test_directed();
        logic [VALUE_W-1:0] fill_vals [15] = '{
            32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'h0000_0000,
            32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'hFFFF_FFFE, 32'h0000_0064,
            32'hFFFF_FF9C, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0007, 32'h4000_0000
        };
        send_idle_pct = 10;
        rx_stall_pct  = 30;
        send_beat(OP_READ_ALL, 32'hFFFF_FFFF);
        send_beat(OP_READ_ODD, 32'h0000_0000);
        send_beat(OP_INSERT, 32'hFFFF_FFFB);
        // Even positions of a one-entry table give nothing.
        send_beat(OP_READ_EVEN, 32'h0000_0000);
        foreach (fill_vals[i])
            send_beat(OP_INSERT, fill_vals[i]);
        send_beat(OP_INSERT, 32'h0000_0000);
        send_beat(OP_READ_ALL, 32'h0000_0000);
        send_beat(OP_READ_ODD, 32'hFFFF_FFFF);
        send_beat(OP_READ_EVEN, 32'h0000_0000);
        send_beat(OP_UNUSED_7, 32'hFFFF_FFFF);
        send_beat(OP_CLEAR, 32'h0000_0000);
        send_beat(OP_READ_EVEN, 32'h0000_0000);
    endtask

    // Mostly fill-and-read sequences with random content, some lone operations,
    // runs of equal values, and ignored opcodes as noise.
    task automatic test_random_traffic(input int send_pct, input int rx_pct, input int n_items);
        int target;
        send_idle_pct = send_pct;
        rx_stall_pct  = rx_pct;
        target        = items_sent + n_items;
        while (items_sent < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    // Skipping the clear now and then lets the table overflow.
                    if ($urandom_range(0, 3) != 0)
                        send_beat(OP_CLEAR, $urandom());
                    repeat ($urandom_range(0, TABLE_DEPTH + 2))
                        send_beat(OP_INSERT, pick_value());
                    repeat ($urandom_range(1, 3))
                        send_beat(pick_read(), $urandom());
                end
                6, 7:
                    send_beat(OPCODE_W'($urandom_range(OP_INSERT, OP_READ_EVEN)), $urandom());
                8:
                    send_beat(OPCODE_W'($urandom_range(OP_UNUSED_5, OP_UNUSED_7)), $urandom());
                default:
                begin
                    repeat ($urandom_range(2, 6))
                        send_beat(OP_INSERT, 32'($urandom_range(0, 3)));
                    send_beat(OP_READ_ALL, $urandom());
                end
            endcase
        end
    endtask

    // The receiver holds off for a long stretch while full-table reads keep coming,
    // so the output side backs up into the input.
    task automatic test_backpressure();
        send_idle_pct = 0;
        rx_stall_pct  = 0;
        hold_request  = 1'b1;
        send_beat(OP_CLEAR, $urandom());
        repeat (TABLE_DEPTH)
            send_beat(OP_INSERT, pick_value());
        repeat (6)
            send_beat(pick_read(), $urandom());
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_traffic(29, 68, 115);
        test_random_traffic(68, 29, 115);
        test_random_traffic(0, 0, 115);
        test_backpressure();

        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_beats.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/stit_pkg.sv
sv/stit_ram.sv
sv/stit_seq.sv
sv/stit_out_reg.sv
sv/sorted_table_insert_split.sv
sim/sorted_table_insert_split_tb.sv
